// File: hdl/ftve_pkg.sv
// ----------------------------------------------------------------------------
// ftve_pkg: shared types and constants of the flat triangle vertex emitter
// Holds the controller states, the command and status structs and field widths.
// ----------------------------------------------------------------------------
`default_nettype none
package ftve_pkg;

    localparam int unsigned CoordW  = 32;
    localparam int unsigned EdgeW   = 33;
    localparam int unsigned CrossW  = 67;
    localparam int unsigned MagW    = 66;
    localparam int unsigned TW      = 31;
    localparam int unsigned SumW    = 64;
    localparam int unsigned LenW    = 32;
    localparam int unsigned NormW   = 16;
    localparam int unsigned TexW    = 15;
    localparam int unsigned IdxW    = 32;
    localparam int unsigned InW     = 9 * CoordW;
    localparam int unsigned OutW    = 3 * CoordW + 3 * NormW + 2 * TexW + IdxW;
    localparam int unsigned OutBytesW = ((OutW + 7) / 8) * 8;
    localparam int unsigned QuoW    = 15;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE,
        ST_MUL,
        ST_CROSS,
        ST_SHIFT,
        ST_SQUARE,
        ST_SQRT,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic edge_en;
        logic mul_en;
        logic cross_en;
        logic shift_en;
        logic square_en;
        logic sqrt_start;
        logic sqrt_step;
        logic div_start;
        logic div_step;
        logic emit_load;
        logic [1:0] corner;
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic [1:0] square_cnt;
    } t_status;

    localparam logic [TexW-1:0] TexOne  = 15'd16384;
    localparam logic [TexW-1:0] TexHalf = 15'd8192;

endpackage
`default_nettype wire

// File: hdl/flat_triangle_vertex_emitter.sv
// ----------------------------------------------------------------------------
// flat_triangle_vertex_emitter: triangle to three flat-shaded vertex words
// Computes the unit face normal and emits one word per corner a, b, c.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis carries one triangle per word: nine signed Q16.16
//   coordinates a_x..c_z. Master channel m_axis carries three vertex words per
//   triangle; tlast marks the word for corner c.
//   From the edge that accepts a triangle to the load of the first vertex
//   word the steps are edge, multiply, cross and scale, three square adds,
//   the bitwise square root (32 result bits), the three parallel restoring
//   dividers (45 quotient steps) and emit. The root and divider loops set
//   the rate, and the next triangle is taken only after the third vertex
//   word is loaded.
//   A one-word output register holds each vertex word; while the receiver
//   stalls the controller waits in emit and no new triangle is taken.
//   Reset clears the controller, the output valid and the vertex index.
// ----------------------------------------------------------------------------
`default_nettype none
module flat_triangle_vertex_emitter (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
    input  wire  [287:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v, vertex_index
    output logic [207:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    ftve_pkg::t_cmd    w_cmd;
    ftve_pkg::t_status w_status;
    logic [ftve_pkg::OutBytesW-1:0] w_word;
    logic r_valid;
    logic [ftve_pkg::OutBytesW-1:0] r_data;
    logic w_free;

    // output register is free when empty or being taken this cycle
    assign w_free = !r_valid || m_axis_tready;

    ftve_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_free (w_free),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ftve_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tri    (s_axis_tdata),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_word   (w_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_cmd.emit_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
        if (w_cmd.emit_load) r_data <= w_word;
    end

    // word bits 205:0 are the fields, bit 206 marks corner c
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {2'b00, r_data[205:0]};
    assign m_axis_tlast  = r_data[206];

endmodule
`default_nettype wire

// File: hdl/ftve_ctrl.sv
// ----------------------------------------------------------------------------
// ftve_ctrl: sequencer of the vertex emitter
// Steps the datapath through edges, cross product, root, divisions and emit.
// ----------------------------------------------------------------------------
`default_nettype none
module ftve_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire                i_out_free,
    input  ftve_pkg::t_status  i_status,
    output ftve_pkg::t_cmd     o_cmd
);

    ftve_pkg::t_state r_state, n_state;
    logic [1:0] r_corner, n_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ftve_pkg::ST_IDLE;
            r_corner <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_corner <= n_corner;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_corner = r_corner;
        case (r_state)
            ftve_pkg::ST_IDLE:   if (i_in_valid) n_state = ftve_pkg::ST_EDGE;
            ftve_pkg::ST_EDGE:   n_state = ftve_pkg::ST_MUL;
            ftve_pkg::ST_MUL:    n_state = ftve_pkg::ST_CROSS;
            ftve_pkg::ST_CROSS:  n_state = ftve_pkg::ST_SHIFT;
            ftve_pkg::ST_SHIFT:  n_state = ftve_pkg::ST_SQUARE;
            ftve_pkg::ST_SQUARE: if (i_status.square_cnt == 2'd2) n_state = ftve_pkg::ST_SQRT;
            ftve_pkg::ST_SQRT:   if (i_status.sqrt_done) n_state = ftve_pkg::ST_DIV;
            ftve_pkg::ST_DIV: begin
                if (i_status.div_done) begin
                    n_state  = ftve_pkg::ST_EMIT;
                    n_corner = 2'd0;
                end
            end
            ftve_pkg::ST_EMIT: begin
                if (i_out_free) begin
                    if (r_corner == 2'd2) begin
                        n_state  = ftve_pkg::ST_IDLE;
                        n_corner = 2'd0;
                    end else begin
                        n_corner = r_corner + 2'd1;
                    end
                end
            end
            default: n_state = ftve_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd        = '0;
        o_cmd.corner = r_corner;
        o_in_ready   = 1'b0;
        case (r_state)
            ftve_pkg::ST_IDLE: begin
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            ftve_pkg::ST_EDGE:   o_cmd.edge_en = 1'b1;
            ftve_pkg::ST_MUL:    o_cmd.mul_en = 1'b1;
            ftve_pkg::ST_CROSS:  o_cmd.cross_en = 1'b1;
            ftve_pkg::ST_SHIFT:  o_cmd.shift_en = 1'b1;
            ftve_pkg::ST_SQUARE: begin
                o_cmd.square_en  = 1'b1;
                o_cmd.sqrt_start = (i_status.square_cnt == 2'd2);
            end
            ftve_pkg::ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                o_cmd.div_start = i_status.sqrt_done;
            end
            ftve_pkg::ST_DIV:  o_cmd.div_step = 1'b1;
            ftve_pkg::ST_EMIT: o_cmd.emit_load = i_out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/ftve_dp.sv
// ----------------------------------------------------------------------------
// ftve_dp: arithmetic of the vertex emitter
// Edges, cross product, scaling, bitwise root, three restoring divisions.
// ----------------------------------------------------------------------------
`default_nettype none
module ftve_dp (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire  [ftve_pkg::InW-1:0]        i_tri,
    input  ftve_pkg::t_cmd                  i_cmd,
    output ftve_pkg::t_status               o_status,
    output logic [ftve_pkg::OutBytesW-1:0]  o_word
);

    localparam int unsigned CW = ftve_pkg::CoordW;
    localparam int unsigned EW = ftve_pkg::EdgeW;

    logic [ftve_pkg::InW-1:0] r_tri;
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [2*EW-1:0] r_p [6];
    logic signed [ftve_pkg::CrossW-1:0] r_cr [3];
    logic [2:0] r_neg;
    logic [ftve_pkg::TW-1:0] r_t [3];
    logic [ftve_pkg::SumW-1:0] r_sum;
    logic [1:0] r_sq_cnt;
    // root
    logic [ftve_pkg::SumW-1:0] r_rem;
    logic [ftve_pkg::LenW-1:0] r_root;
    logic [5:0] r_sq_step;
    logic r_sqrt_done;
    // divisions
    logic [ftve_pkg::TW+14-1:0] r_num [3];
    logic [ftve_pkg::LenW:0] r_drem [3];
    logic [ftve_pkg::QuoW-1:0] r_quo [3];
    logic [5:0] r_div_step;
    logic r_div_done;
    logic [ftve_pkg::LenW-1:0] r_len;
    logic [ftve_pkg::IdxW-1:0] r_idx;

    function automatic logic signed [EW-1:0] crd(input logic [ftve_pkg::InW-1:0] t,
                                                 input int unsigned k);
        crd = EW'(signed'(t[k*CW +: CW]));
    endfunction

    // shift amount from the OR of magnitudes
    logic [ftve_pkg::MagW-1:0] w_mag [3];
    logic [ftve_pkg::MagW-1:0] w_or;
    logic [6:0] w_len_bits;
    logic [6:0] w_shift;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_cr[i][ftve_pkg::CrossW-1] ? ftve_pkg::MagW'(-r_cr[i])
                                                   : ftve_pkg::MagW'(r_cr[i]);
        end
        w_or = w_mag[0] | w_mag[1] | w_mag[2];
        w_len_bits = 7'd0;
        for (int b = 0; b < ftve_pkg::MagW; b++) begin
            if (w_or[b]) w_len_bits = 7'(b + 1);
        end
        w_shift = (w_len_bits > 7'd31) ? w_len_bits - 7'd31 : 7'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqrt_done <= 1'b0;
            r_div_done  <= 1'b0;
            r_sq_cnt    <= 2'd0;
            r_idx       <= '0;
        end else begin
            if (i_cmd.load) r_tri <= i_tri;
            if (i_cmd.edge_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_e1[i] <= crd(r_tri, 3 + i) - crd(r_tri, i);
                    r_e2[i] <= crd(r_tri, 6 + i) - crd(r_tri, i);
                end
            end
            if (i_cmd.mul_en) begin
                r_p[0] <= r_e1[1] * r_e2[2];
                r_p[1] <= r_e1[2] * r_e2[1];
                r_p[2] <= r_e1[2] * r_e2[0];
                r_p[3] <= r_e1[0] * r_e2[2];
                r_p[4] <= r_e1[0] * r_e2[1];
                r_p[5] <= r_e1[1] * r_e2[0];
            end
            if (i_cmd.cross_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_cr[i] <= ftve_pkg::CrossW'(r_p[2*i]) - ftve_pkg::CrossW'(r_p[2*i+1]);
                end
            end
            if (i_cmd.shift_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_t[i]   <= ftve_pkg::TW'(w_mag[i] >> w_shift);
                    r_neg[i] <= r_cr[i][ftve_pkg::CrossW-1];
                end
                r_sum    <= '0;
                r_sq_cnt <= 2'd0;
            end
            // accumulate one square per cycle
            if (i_cmd.square_en) begin
                r_sum    <= r_sum + ftve_pkg::SumW'(r_t[r_sq_cnt] * r_t[r_sq_cnt]);
                r_sq_cnt <= r_sq_cnt + 2'd1;
            end
            // bitwise root, one result bit per cycle
            if (i_cmd.sqrt_start) begin
                r_rem       <= r_sum + ftve_pkg::SumW'(r_t[2] * r_t[2]);
                r_root      <= '0;
                r_sq_step   <= 6'd31;
                r_sqrt_done <= 1'b0;
            end else if (i_cmd.sqrt_step && !r_sqrt_done) begin
                if (r_rem >= (({32'd0, r_root} << (r_sq_step + 6'd1))
                              | (64'd1 << (2 * r_sq_step)))) begin
                    r_rem  <= r_rem - ((({32'd0, r_root} << (r_sq_step + 6'd1)))
                                       | (64'd1 << (2 * r_sq_step)));
                    r_root <= r_root | (32'd1 << r_sq_step);
                end
                if (r_sq_step == 6'd0) r_sqrt_done <= 1'b1;
                else r_sq_step <= r_sq_step - 6'd1;
            end
            // restoring division, three lanes, one quotient bit per cycle
            if (i_cmd.div_start) begin
                r_len <= r_root;
                for (int i = 0; i < 3; i++) begin
                    r_num[i]  <= {r_t[i], 14'd0};
                    r_drem[i] <= '0;
                    r_quo[i]  <= '0;
                end
                r_div_step <= 6'd44;
                r_div_done <= 1'b0;
            end else if (i_cmd.div_step && !r_div_done) begin
                for (int i = 0; i < 3; i++) begin
                    logic [ftve_pkg::LenW:0] v_r;
                    v_r = {r_drem[i][ftve_pkg::LenW-1:0], r_num[i][r_div_step]};
                    if (r_len != '0 && v_r >= {1'b0, r_len}) begin
                        r_drem[i] <= v_r - {1'b0, r_len};
                        r_quo[i]  <= {r_quo[i][ftve_pkg::QuoW-2:0], 1'b1};
                    end else begin
                        r_drem[i] <= v_r;
                        r_quo[i]  <= {r_quo[i][ftve_pkg::QuoW-2:0], 1'b0};
                    end
                end
                if (r_div_step == 6'd0) r_div_done <= 1'b1;
                else r_div_step <= r_div_step - 6'd1;
            end
            if (i_cmd.emit_load) r_idx <= r_idx + 32'd1;
        end
    end

    assign o_status.sqrt_done  = r_sqrt_done;
    assign o_status.div_done   = r_div_done;
    assign o_status.square_cnt = r_sq_cnt;

    // output word for the selected corner
    logic [ftve_pkg::NormW-1:0] w_nrm [3];
    logic [ftve_pkg::TexW-1:0] w_u, w_v;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_nrm[i] = r_neg[i] ? -{1'b0, r_quo[i]} : {1'b0, r_quo[i]};
        end
        case (i_cmd.corner)
            2'd0:    begin w_u = '0;                w_v = '0;              end
            2'd1:    begin w_u = ftve_pkg::TexOne;  w_v = '0;              end
            default: begin w_u = ftve_pkg::TexHalf; w_v = ftve_pkg::TexOne; end
        endcase
        o_word = ftve_pkg::OutBytesW'({(i_cmd.corner == 2'd2), r_idx, w_v, w_u,
                  w_nrm[2], w_nrm[1], w_nrm[0],
                  r_tri[(3*i_cmd.corner+2)*CW +: CW],
                  r_tri[(3*i_cmd.corner+1)*CW +: CW],
                  r_tri[(3*i_cmd.corner)*CW +: CW]});
    end

endmodule
`default_nettype wire
